>>> rtl/core/bolt_pkg.sv
// Shared types and codes for the bounded ordered list table.
// No dependencies; used by bolt_out, bolt_ctrl and the top level under rtl/core.
`timescale 1ns / 1ps

package bolt_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned LEN_W = 6;

  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [1:0] {
    REQ_INS  = 2'd0,
    REQ_DEL  = 2'd1,
    REQ_DVAL = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_POS_ZERO  = 3'd2,
    ST_BEYOND    = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_DVAL_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    len_t    len;
    status_t status;
  } res_t;

endpackage

>>> rtl/core/bolt_mem.sv
// Entry store: one write port and one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module bolt_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_q[rd_addr];
    end
  end

endmodule

>>> rtl/core/bolt_out.sv
// Result register between the sequencer and the result stream.
// Depends on bolt_pkg (res_t).
`timescale 1ns / 1ps

module bolt_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bolt_pkg::res_t    res_in,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata   // [2:0] status, [8:3] list_length
);

  logic           valid_r;
  logic           valid_nxt;
  bolt_pkg::res_t res_r;

  assign free      = !valid_r || out_tready;
  assign valid_nxt = push ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res_in;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, res_r.len, res_r.status};

endmodule

>>> rtl/core/bolt_ctrl.sv
// Request sequencer: decodes a request and moves entries through the store
// by read-modify-write. Depends on bolt_pkg; drives bolt_mem.
`timescale 1ns / 1ps

module bolt_ctrl #(
  parameter int unsigned MAX_LEN = 32,
  parameter int unsigned AW      = 5,
  parameter int unsigned CW      = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  bolt_pkg::req_t                req_type,
  input  logic [bolt_pkg::POS_W-1:0]    position,
  input  logic [bolt_pkg::VAL_W-1:0]    item_value,
  input  logic                          out_free,
  output logic                          res_push,
  output bolt_pkg::res_t                res,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [bolt_pkg::VAL_W-1:0]    mem_wr_data,
  output logic                          mem_rd_en,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [bolt_pkg::VAL_W-1:0]    mem_rd_data
);

  localparam int unsigned PW = CW + bolt_pkg::POS_W;

  bolt_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                slot_r, slot_nxt;
  logic [CW-1:0]                wr_r, wr_nxt;
  logic [bolt_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic                         pend_r, pend_nxt;
  logic [AW-1:0]                pend_addr_r, pend_addr_nxt;
  logic                         chk_r, chk_nxt;
  bolt_pkg::status_t            status_r, status_nxt;

  logic                         full;
  logic                         pos_zero;
  logic                         beyond;
  logic [bolt_pkg::POS_W-1:0]   pos_m1;
  logic [CW-1:0]                slot_clip;
  logic [CW-1:0]                idx_inc;
  logic [CW-1:0]                idx_dec;
  logic                         more_del;
  logic                         accept;

  assign full      = (cnt_r == CW'(MAX_LEN));
  assign pos_zero  = (position == '0);
  assign beyond    = (PW'(position) > PW'(cnt_r));
  assign pos_m1    = position - 1'b1;
  assign slot_clip = (PW'(pos_m1) > PW'(cnt_r)) ? cnt_r : CW'(pos_m1);
  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign more_del  = ((CW+1)'(idx_r) + (CW+1)'(1)) < (CW+1)'(cnt_r);
  assign accept    = req_valid && req_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bolt_pkg::S_IDLE: begin
        if (req_valid) begin
          case (req_type)
            bolt_pkg::REQ_INS:
              state_nxt = (full || pos_zero) ? bolt_pkg::S_FINISH : bolt_pkg::S_INS_SHIFT;
            bolt_pkg::REQ_DEL:
              state_nxt = (beyond || pos_zero) ? bolt_pkg::S_FINISH : bolt_pkg::S_DEL_SHIFT;
            bolt_pkg::REQ_DVAL:
              state_nxt = bolt_pkg::S_DVAL_SCAN;
            default:
              state_nxt = bolt_pkg::S_FINISH;
          endcase
        end
      end
      bolt_pkg::S_INS_SHIFT: begin
        if (!(idx_r > slot_r)) begin
          state_nxt = bolt_pkg::S_INS_PUT;
        end
      end
      bolt_pkg::S_INS_PUT: begin
        state_nxt = bolt_pkg::S_FINISH;
      end
      bolt_pkg::S_DEL_SHIFT: begin
        if (!more_del) begin
          state_nxt = bolt_pkg::S_FINISH;
        end
      end
      bolt_pkg::S_DVAL_SCAN: begin
        if (idx_r == cnt_r && !chk_r) begin
          state_nxt = bolt_pkg::S_FINISH;
        end
      end
      bolt_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = bolt_pkg::S_IDLE;
        end
      end
      default: state_nxt = bolt_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready     = (state_r == bolt_pkg::S_IDLE);
    res_push      = 1'b0;
    res.status    = status_r;
    res.len       = bolt_pkg::len_t'(cnt_r);
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    wr_nxt        = wr_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    chk_nxt       = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;

    // complete the write half of a shift issued last cycle
    if (pend_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = pend_addr_r;
      mem_wr_data = mem_rd_data;
    end

    unique case (state_r)
      bolt_pkg::S_IDLE: begin
        if (accept) begin
          val_nxt    = item_value;
          status_nxt = bolt_pkg::ST_OK;
          case (req_type)
            bolt_pkg::REQ_INS: begin
              if (full) begin
                status_nxt = bolt_pkg::ST_FULL;
              end else if (pos_zero) begin
                status_nxt = bolt_pkg::ST_POS_ZERO;
              end else begin
                slot_nxt = slot_clip;
                idx_nxt  = cnt_r;
              end
            end
            bolt_pkg::REQ_DEL: begin
              if (beyond) begin
                status_nxt = bolt_pkg::ST_BEYOND;
              end else if (pos_zero) begin
                status_nxt = bolt_pkg::ST_POS_ZERO;
              end else begin
                idx_nxt = CW'(pos_m1);
              end
            end
            bolt_pkg::REQ_DVAL: begin
              idx_nxt = '0;
              wr_nxt  = '0;
            end
            default: begin
              status_nxt = bolt_pkg::ST_OK;
            end
          endcase
        end
      end
      bolt_pkg::S_INS_SHIFT: begin
        if (idx_r > slot_r) begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = idx_dec[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_dec;
        end
      end
      bolt_pkg::S_INS_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = slot_r[AW-1:0];
        mem_wr_data = val_r;
        cnt_nxt     = cnt_r + 1'b1;
      end
      bolt_pkg::S_DEL_SHIFT: begin
        if (more_del) begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = idx_inc[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_inc;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      bolt_pkg::S_DVAL_SCAN: begin
        if (idx_r != cnt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r[AW-1:0];
          idx_nxt     = idx_inc;
          chk_nxt     = 1'b1;
        end
        // keep entries that differ, packed down to the write pointer
        if (chk_r && (mem_rd_data != val_r)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_r[AW-1:0];
          mem_wr_data = mem_rd_data;
          wr_nxt      = wr_r + 1'b1;
        end
        if (idx_r == cnt_r && !chk_r) begin
          if (wr_r == cnt_r) begin
            status_nxt = bolt_pkg::ST_NOT_FOUND;
          end else begin
            cnt_nxt = wr_r;
          end
        end
      end
      bolt_pkg::S_FINISH: begin
        res_push = out_free;
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bolt_pkg::S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    slot_r      <= slot_nxt;
    wr_r        <= wr_nxt;
    val_r       <= val_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_LEN))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("read and write to the same entry in one cycle");

  a_idle_holds_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bolt_pkg::S_IDLE) |=> (cnt_r == $past(cnt_r)))
    else $error("entry count changed without a request in progress");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bolt_pkg::S_INS_PUT) |=> (cnt_r == CW'($past(cnt_r) + 1'b1)))
    else $error("insert did not grow the list by one");

  a_push_finish: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (state_r == bolt_pkg::S_FINISH) && out_free)
    else $error("result pushed outside the finish step");

endmodule

>>> rtl/core/bounded_ordered_list_table.sv
// Bounded ordered list table, top level: one request in flight at a time.
// Refused and unused requests go straight to the result; insert moves entries
// up one at a time and then writes the item, delete moves entries down, and
// delete by value scans every entry. The next request is taken only after
// the result of the previous one has been registered.
// Synchronous active-low reset empties the list; store contents are not cleared.
`timescale 1ns / 1ps

module bounded_ordered_list_table #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] item_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [8:3] list_length
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic                         out_free;
  logic                         res_push;
  bolt_pkg::res_t               res;
  logic                         mem_wr_en;
  logic [AW-1:0]                mem_wr_addr;
  logic [bolt_pkg::VAL_W-1:0]   mem_wr_data;
  logic                         mem_rd_en;
  logic [AW-1:0]                mem_rd_addr;
  logic [bolt_pkg::VAL_W-1:0]   mem_rd_data;

  bolt_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW),
    .DW    (bolt_pkg::VAL_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bolt_ctrl #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_type    (bolt_pkg::req_t'(in_tuser)),
    .position    (in_tdata[7:0]),
    .item_value  (in_tdata[39:8]),
    .out_free    (out_free),
    .res_push    (res_push),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  bolt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .res_in     (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/list_table_checker.sv
// Checker for the bounded ordered list table: watches both stream channels,
// keeps its own copy of the list and compares every result. Depends on bolt_pkg.
`timescale 1ns / 1ps

module list_table_checker #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] item_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [2:0] status, [8:3] list_length
  output int unsigned fail_count,
  output int unsigned pending
);

  logic [bolt_pkg::VAL_W-1:0] list_vals [MAX_LEN];
  int unsigned                list_len;
  bolt_pkg::res_t             expected_results [$];

  function automatic bolt_pkg::res_t apply_request(logic [1:0] kind,
                                                   logic [bolt_pkg::POS_W-1:0] pos,
                                                   logic [bolt_pkg::VAL_W-1:0] value);
    bolt_pkg::res_t res;
    int unsigned    slot;
    int unsigned    wr;
    res.status = bolt_pkg::ST_OK;
    case (kind)
      bolt_pkg::REQ_INS: begin
        if (list_len >= MAX_LEN) begin
          res.status = bolt_pkg::ST_FULL;
        end else if (pos == '0) begin
          res.status = bolt_pkg::ST_POS_ZERO;
        end else begin
          slot = pos - 1;
          if (slot > list_len) slot = list_len;
          for (int unsigned k = list_len; k > slot; k--) list_vals[k] = list_vals[k-1];
          list_vals[slot] = value;
          list_len++;
        end
      end
      bolt_pkg::REQ_DEL: begin
        if (pos > list_len) begin
          res.status = bolt_pkg::ST_BEYOND;
        end else if (pos == '0) begin
          res.status = bolt_pkg::ST_POS_ZERO;
        end else begin
          for (int unsigned k = pos - 1; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
          list_len--;
        end
      end
      bolt_pkg::REQ_DVAL: begin
        wr = 0;
        for (int unsigned k = 0; k < list_len; k++) begin
          if (list_vals[k] != value) begin
            list_vals[wr] = list_vals[k];
            wr++;
          end
        end
        if (wr == list_len) res.status = bolt_pkg::ST_NOT_FOUND;
        else list_len = wr;
      end
      default: res.status = bolt_pkg::ST_OK;
    endcase
    res.len = bolt_pkg::len_t'(list_len);
    return res;
  endfunction

  function automatic void note_failure(string what, bolt_pkg::res_t want,
                                       logic [15:0] got);
    if (fail_count < 10)
      $display("%0t: %s: expected status %0d length %0d, got status %0d length %0d",
               $realtime, what, want.status, want.len, got[2:0], got[8:3]);
    fail_count++;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
  end

  always @(posedge clk) begin
    bolt_pkg::res_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      // retire results before taking the new request
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          want = '0;
          note_failure("unexpected result", want, out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[2:0] != want.status || out_tdata[8:3] != want.len ||
              out_tdata[15:9] != '0)
            note_failure("result mismatch", want, out_tdata);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_request(in_tuser, in_tdata[7:0], in_tdata[39:8]));
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the bounded ordered list table: clock, reset, request
// stimulus with idling and stalls, and the verdict. Uses list_table_checker.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_LEN    = 32;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT  = 600000;
  localparam int unsigned PHASE_REQS = 550;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [7:0] position, [39:8] item_value
  logic [1:0]  in_tuser   = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [2:0] status, [8:3] list_length

  int unsigned fail_count;
  int unsigned pending;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;

  bounded_ordered_list_table #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  list_table_checker #(.MAX_LEN(MAX_LEN)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [7:0] pos, logic [31:0] value);
    bit taken;
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, pos};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3, 4, 5: return 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  // grow episodes push towards a full list, shrink episodes push it back towards empty
  task automatic run_phase(int unsigned reqs);
    int unsigned left;
    int unsigned roll;
    bit          grow;
    logic [1:0]  kind;
    logic [7:0]  pos;
    left = 0;
    grow = 1'b1;
    repeat (reqs) begin
      if (left == 0) begin
        left = $urandom_range(20, 60);
        grow = ~grow;
      end
      left--;
      roll = $urandom_range(99);
      if (roll < 2)                     kind = REQ_UNUSED;
      else if (roll < (grow ? 82 : 27)) kind = bolt_pkg::REQ_INS;
      else if (roll < (grow ? 92 : 77)) kind = bolt_pkg::REQ_DEL;
      else                              kind = bolt_pkg::REQ_DVAL;
      pos = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(34));
      send_request(kind, pos, pick_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(bolt_pkg::REQ_DVAL, 8'd0,   32'h0000_0000);
    send_request(bolt_pkg::REQ_DEL,  8'd1,   32'h0000_0000);
    send_request(bolt_pkg::REQ_DEL,  8'd0,   32'h0000_0000);
    send_request(bolt_pkg::REQ_INS,  8'd0,   32'h1234_5678);
    send_request(bolt_pkg::REQ_INS,  8'd1,   32'h7fff_ffff);
    send_request(bolt_pkg::REQ_INS,  8'd255, 32'h8000_0000);
    send_request(bolt_pkg::REQ_INS,  8'd1,   32'hffff_ffff);
    send_request(bolt_pkg::REQ_INS,  8'd2,   32'h0000_0000);
    send_request(bolt_pkg::REQ_INS,  8'd3,   32'h8000_0000);
    send_request(REQ_UNUSED,         8'd255, 32'hffff_ffff);
    send_request(bolt_pkg::REQ_DVAL, 8'd255, 32'h8000_0000);
    send_request(bolt_pkg::REQ_DEL,  8'd255, 32'h0000_0000);
    send_request(bolt_pkg::REQ_DEL,  8'd0,   32'h0000_0000);
    send_request(bolt_pkg::REQ_DEL,  8'd2,   32'h0000_0000);
    send_request(bolt_pkg::REQ_INS,  8'd200, 32'h5a5a_5a5a);
    send_request(bolt_pkg::REQ_INS,  8'd1,   32'ha5a5_a5a5);
    send_request(bolt_pkg::REQ_DVAL, 8'd0,   32'h0000_3039);
    send_request(bolt_pkg::REQ_DEL,  8'd1,   32'h0000_0000);
    send_request(bolt_pkg::REQ_DEL,  8'd3,   32'h0000_0000);
    send_request(bolt_pkg::REQ_DVAL, 8'd1,   32'h7fff_ffff);
    drain_results();

    gap_pct   = 21;
    stall_pct = 58;
    run_phase(PHASE_REQS);
    drain_results();

    gap_pct   = 58;
    stall_pct = 21;
    run_phase(PHASE_REQS);
    drain_results();

    gap_pct   = 0;
    stall_pct = 0;
    run_phase(PHASE_REQS);
    drain_results();

    repeat (MAX_LEN + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
